// ----- hdl/tclr_pkg.sv -----
// ---------------------------------------------------------------------------
// tclr_pkg: shared types and constants for the console line ring
// Operation codes, control characters and default sizes of the ring.
// ---------------------------------------------------------------------------
package tclr_pkg;

  // default geometry of the ring
  localparam int LINES_DEF      = 32;
  localparam int LINE_CHARS_DEF = 128;

  // field widths fixed by the interface
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int BACK_W   = 5;
  localparam int COL_W    = 7;
  localparam int LENO_W   = 7;
  localparam int LIMIT_W  = 7;

  // line limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd50;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

  // range of codes that are appended to the line
  localparam logic [CHAR_W-1:0] PRINT_LO = 8'd21;
  localparam logic [CHAR_W-1:0] PRINT_HI = 8'd127;

endpackage

// ----- hdl/text_console_line_ring_unit.sv -----
// ---------------------------------------------------------------------------
// text_console_line_ring_unit: scrollback ring of console text lines
// Appends characters to the head line, handles newline, backspace and
// carriage return, and reads single cells of lines counted back from head.
// ---------------------------------------------------------------------------
// The unit takes one beat per clock cycle and returns exactly one result beat
// for each from its result register, in the cycle after it is accepted; a new
// beat is taken in the same cycle as a waiting result is taken, so the
// sustained rate is one beat per cycle with out_ready held high. All state
// changes of a beat (head and tail line, head line length, cell and length
// writes) happen at the edge that accepts it, and the cell store and the
// length table are read at that same edge through their single registered
// read ports, so a read sees every earlier put. The head line length lives
// in a register; the length table is only read for lines that left the
// head, so a clear needs no clearing pass. The user must write line_limit
// through cfg_we / cfg_wdata only while the unit is idle; nothing enforces it.
module text_console_line_ring_unit #(
  parameter int LINES      = tclr_pkg::LINES_DEF,
  parameter int LINE_CHARS = tclr_pkg::LINE_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [tclr_pkg::LIMIT_W-1:0]  cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tclr_pkg::OP_W-1:0]     op,
  input  logic [tclr_pkg::CHAR_W-1:0]   char_code,
  input  logic [tclr_pkg::BACK_W-1:0]   lines_back,
  input  logic [tclr_pkg::COL_W-1:0]    column,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tclr_pkg::CHAR_W-1:0]   read_char,
  output logic [tclr_pkg::LENO_W-1:0]   line_length,
  output logic                          in_history
);

  // line index, cell index, length and store address widths
  localparam int LIW   = $clog2(LINES);
  localparam int CIW   = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam int LEN_W = $clog2(LINE_CHARS + 1);
  localparam int AW    = $clog2(LINES * LINE_CHARS);
  localparam int DEPTH = LINES * LINE_CHARS;
  // compare widths
  localparam int BW    = (LIW > tclr_pkg::BACK_W) ? LIW : tclr_pkg::BACK_W;
  localparam int CCW   = (CIW > tclr_pkg::COL_W) ? CIW : tclr_pkg::COL_W;
  localparam int CMPW  = (LEN_W > tclr_pkg::COL_W) ? LEN_W : tclr_pkg::COL_W;

  localparam logic [LIW-1:0]  LAST_LINE = LIW'(LINES - 1);
  localparam logic [LIW:0]    LINES_X   = (LIW + 1)'(LINES);
  localparam logic [AW-1:0]   CHARS_A   = AW'(LINE_CHARS);
  localparam logic [CMPW-1:0] MAX_LIM   = CMPW'(LINE_CHARS - 1);

  // ring state
  logic [LIW-1:0]                 head;
  logic [LIW-1:0]                 head_next;
  logic [LIW-1:0]                 tail;
  logic [LIW-1:0]                 tail_next;
  logic [LEN_W-1:0]               head_len;
  logic [LEN_W-1:0]               head_len_next;
  logic [tclr_pkg::LIMIT_W-1:0]   line_limit;

  // storage: cells of all lines, lengths of lines that left the head
  logic [tclr_pkg::CHAR_W-1:0]    cell_mem [DEPTH];
  logic [LEN_W-1:0]               len_mem  [LINES];
  logic [tclr_pkg::CHAR_W-1:0]    cell_q;
  logic [LEN_W-1:0]               len_q;

  // result register
  logic                           res_hist;
  logic                           res_use_mem;
  logic [LEN_W-1:0]               res_len;
  logic [tclr_pkg::COL_W-1:0]     res_col;

  logic                           accept;
  tclr_pkg::op_t                  op_in;

  // put path
  logic [CMPW-1:0]                lim_w;
  logic [LEN_W-1:0]               lim;
  logic [LEN_W-1:0]               len_clamp;
  logic [LEN_W-1:0]               len_wb;
  logic                           advance;
  logic                           printable;
  logic [LIW-1:0]                 head_inc;
  logic [LIW-1:0]                 tail_inc;

  // read path
  logic [LIW-1:0]                 span;
  logic [LIW:0]                   span_wrap;
  logic [BW-1:0]                  back_w;
  logic [LIW-1:0]                 back_l;
  logic [LIW:0]                   line_wrap;
  logic [LIW-1:0]                 line_sel;
  logic                           hist;
  logic [CCW-1:0]                 col_w;
  logic [CIW-1:0]                 col_cell;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;

  // result shaping
  logic [LEN_W-1:0]               len_out;
  logic [LEN_W+tclr_pkg::LENO_W-1:0] len_out_x;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign op_in    = tclr_pkg::op_t'(op);

  // limit in use never lets a cell index leave its line
  assign lim_w = (CMPW'(line_limit) > MAX_LIM) ? MAX_LIM : CMPW'(line_limit);
  assign lim   = LEN_W'(lim_w);

  assign printable = (char_code >= tclr_pkg::PRINT_LO) && (char_code <= tclr_pkg::PRINT_HI);
  assign len_clamp = (head_len > lim) ? lim : head_len;

  assign head_inc = (head == LAST_LINE) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST_LINE) ? '0 : tail + 1'b1;

  // length of the current head line once this character is applied
  always_comb begin
    len_wb  = head_len;
    advance = 1'b0;
    if (char_code == tclr_pkg::CH_NEWLINE) begin
      advance = 1'b1;
    end else if (char_code == tclr_pkg::CH_BACKSPACE) begin
      if (head_len != '0) begin
        len_wb = head_len - 1'b1;
      end
    end else if (char_code == tclr_pkg::CH_RETURN) begin
      len_wb = '0;
    end else if (printable) begin
      len_wb  = len_clamp + 1'b1;
      advance = (len_wb > lim);
    end
  end

  // next ring state
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    head_len_next = head_len;
    case (op_in)
      tclr_pkg::OP_PUT: begin
        if (advance) begin
          head_next     = head_inc;
          head_len_next = '0;
          // head caught up with the tail: drop the oldest line
          if (head_inc == tail) begin
            tail_next = tail_inc;
          end
        end else begin
          head_len_next = len_wb;
        end
      end
      tclr_pkg::OP_CLEAR: begin
        head_next     = '0;
        tail_next     = '0;
        head_len_next = '0;
      end
      default: begin
      end
    endcase
  end

  // lines between tail and head, head included
  assign span_wrap = {1'b0, head} + LINES_X - {1'b0, tail};
  assign span      = (head >= tail) ? head - tail : span_wrap[LIW-1:0];
  assign back_w    = BW'(lines_back);
  assign hist      = (back_w < BW'(span));
  assign back_l    = back_w[LIW-1:0];
  assign line_wrap = {1'b0, head} + LINES_X - {1'b0, back_l};
  assign line_sel  = (head >= back_l) ? head - back_l : line_wrap[LIW-1:0];

  assign col_w    = CCW'(column);
  assign col_cell = col_w[CIW-1:0];
  assign rd_addr  = AW'(line_sel) * CHARS_A + AW'(col_cell);
  assign wr_addr  = AW'(head) * CHARS_A + AW'(len_clamp[CIW-1:0]);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= LIW'(1);
      tail       <= '0;
      head_len   <= '0;
      line_limit <= tclr_pkg::LIMIT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_limit <= cfg_wdata;
      end
      if (accept) begin
        head     <= head_next;
        tail     <= tail_next;
        head_len <= head_len_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // cell store: one write for a printable put, one registered read
  always_ff @(posedge clk) begin
    if (accept && (op_in == tclr_pkg::OP_PUT) && printable) begin
      cell_mem[wr_addr] <= char_code;
    end
    if (accept) begin
      cell_q <= cell_mem[rd_addr];
    end
  end

  // length table: every put writes back the head line's length
  always_ff @(posedge clk) begin
    if (accept && (op_in == tclr_pkg::OP_PUT)) begin
      len_mem[head] <= len_wb;
    end
    if (accept) begin
      len_q <= len_mem[line_sel];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_col <= column;
      case (op_in)
        tclr_pkg::OP_PUT: begin
          res_hist    <= 1'b0;
          res_use_mem <= 1'b0;
          res_len     <= head_len_next;
        end
        tclr_pkg::OP_READ: begin
          res_hist    <= hist;
          // the head line length is only current in its register
          res_use_mem <= hist && (back_l != '0);
          res_len     <= hist ? head_len : '0;
        end
        default: begin
          res_hist    <= 1'b0;
          res_use_mem <= 1'b0;
          res_len     <= '0;
        end
      endcase
    end
  end

  assign len_out     = res_use_mem ? len_q : res_len;
  assign len_out_x   = (LEN_W + tclr_pkg::LENO_W)'(len_out);
  assign line_length = len_out_x[tclr_pkg::LENO_W-1:0];
  assign in_history  = res_hist;
  // cells at or past the line length read as zero
  assign read_char   = (res_hist && (CMPW'(res_col) < CMPW'(len_out))) ? cell_q : '0;

  // checks
  a_head_len_in_line: assert property (@(posedge clk) disable iff (rst)
    head_len < LEN_W'(LINE_CHARS))
    else $error("head line length reached the line size");

  a_no_char_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_history |-> read_char == '0)
    else $error("character returned outside history");

  a_newline_empty: assert property (@(posedge clk) disable iff (rst)
    accept && (op_in == tclr_pkg::OP_PUT) && (char_code == tclr_pkg::CH_NEWLINE)
    |=> out_valid && (line_length == '0) && (head_len == '0))
    else $error("new head line not empty after newline");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (op_in == tclr_pkg::OP_CLEAR) |=> (head == tail) && !in_history)
    else $error("ring not empty after clear");

endmodule

// ----- sim/text_console_line_ring_unit_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_console_line_ring_unit_tb: self-checking bench for the console line ring
// Sends put, read, clear and spare-op beats with random idling on both sides,
// predicts every result from a private copy of the ring and checks results in
// order, while line_limit is swept through its extremes between phases.
// ---------------------------------------------------------------------------
module text_console_line_ring_unit_tb;

  // geometry of the ring under test (defaults of the unit)
  localparam int NLINES = tclr_pkg::LINES_DEF;
  localparam int NCOLS  = tclr_pkg::LINE_CHARS_DEF;

  // op code that the unit leaves unused
  localparam logic [tclr_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  localparam int MAX_GAP     = 17;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE      = 4;       // margin past the result register
  localparam int CYCLE_LIMIT = 600000;  // watchdog bound for the whole run
  localparam int PHASE_BEATS = 160;

  // one input beat; aim asks for the read position to be steered at send time
  typedef struct packed {
    logic [tclr_pkg::OP_W-1:0]   op;
    logic [tclr_pkg::CHAR_W-1:0] ch;
    logic [tclr_pkg::BACK_W-1:0] back;
    logic [tclr_pkg::COL_W-1:0]  col;
    logic                        aim;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic [tclr_pkg::CHAR_W-1:0] ch;
    logic [tclr_pkg::LENO_W-1:0] len;
    logic                        hist;
  } cell_read_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [tclr_pkg::LIMIT_W-1:0]  cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic [tclr_pkg::OP_W-1:0]     op;
  logic [tclr_pkg::CHAR_W-1:0]   char_code;
  logic [tclr_pkg::BACK_W-1:0]   lines_back;
  logic [tclr_pkg::COL_W-1:0]    column;
  logic                          out_valid;
  logic                          out_ready;
  logic [tclr_pkg::CHAR_W-1:0]   read_char;
  logic [tclr_pkg::LENO_W-1:0]   line_length;
  logic                          in_history;

  // private copy of the ring; lengths are kept wide since a full line of
  // NCOLS cells does not fit the 7-bit length port
  logic [tclr_pkg::CHAR_W-1:0] ring_cells [NLINES*NCOLS];
  int                          ring_len   [NLINES];
  int                          ring_head;
  int                          ring_tail;
  int                          ring_limit;

  cell_read_t pending_q [$];   // predicted results, oldest first
  int         mismatches;
  int         cycles;
  bit         in_idle;         // sender draws gaps when set
  bit         out_idle;        // receiver draws stalls when set

  text_console_line_ring_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .char_code   (char_code),
    .lines_back  (lines_back),
    .column      (column),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_char   (read_char),
    .line_length (line_length),
    .in_history  (in_history)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // ring predictor
  // ------------------------------------------------------------------

  // state after reset: head on line 1, tail on line 0, every line empty
  function automatic void ring_reset();
    for (int i = 0; i < NLINES*NCOLS; i++) ring_cells[i] = '0;
    for (int i = 0; i < NLINES; i++) ring_len[i] = 0;
    ring_head  = 1 % NLINES;
    ring_tail  = 0;
    ring_limit = int'(tclr_pkg::LIMIT_RESET);
  endfunction

  // move to a fresh head line, dropping the oldest line when the ring is full
  function automatic void advance_head();
    ring_head = (ring_head + 1) % NLINES;
    if (ring_head == ring_tail) ring_tail = (ring_tail + 1) % NLINES;
    ring_len[ring_head] = 0;
  endfunction

  function automatic void put_char(logic [tclr_pkg::CHAR_W-1:0] c);
    int lim;
    int len;
    // limit clamped so a cell index never leaves the line
    lim = (ring_limit > NCOLS - 1) ? NCOLS - 1 : ring_limit;
    len = ring_len[ring_head];
    if (c == tclr_pkg::CH_NEWLINE) begin
      advance_head();
    end else if (c == tclr_pkg::CH_BACKSPACE) begin
      // backspace on an empty line is a no-op
      if (len > 0) ring_len[ring_head] = len - 1;
    end else if (c == tclr_pkg::CH_RETURN) begin
      ring_len[ring_head] = 0;
    end else if (c >= tclr_pkg::PRINT_LO && c <= tclr_pkg::PRINT_HI) begin
      if (len > lim) len = lim;
      ring_cells[ring_head*NCOLS + len] = c;
      len++;
      ring_len[ring_head] = len;
      // wrap once the line runs past the limit
      if (len > lim) advance_head();
    end
    // every other code leaves the ring alone
  endfunction

  function automatic cell_read_t predict_beat(beat_t b);
    cell_read_t r;
    int         span;
    int         line;
    r = '0;
    case (b.op)
      tclr_pkg::OP_PUT: begin
        put_char(b.ch);
        r.len = tclr_pkg::LENO_W'(ring_len[ring_head]);
      end
      tclr_pkg::OP_READ: begin
        // lines between tail (excluded) and head (included)
        span = (ring_head + NLINES - ring_tail) % NLINES;
        if (b.back < span) begin
          line   = (ring_head + NLINES - b.back) % NLINES;
          r.hist = 1'b1;
          r.len  = tclr_pkg::LENO_W'(ring_len[line]);
          if (b.col < ring_len[line] && b.col < NCOLS) r.ch = ring_cells[line*NCOLS + b.col];
        end
      end
      tclr_pkg::OP_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
        for (int i = 0; i < NLINES; i++) ring_len[i] = 0;
      end
      default: begin
        // spare op: all-zero result
      end
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  function automatic beat_t mk_beat(logic [tclr_pkg::OP_W-1:0] o,
                                    logic [tclr_pkg::CHAR_W-1:0] c,
                                    logic [tclr_pkg::BACK_W-1:0] bk,
                                    logic [tclr_pkg::COL_W-1:0] cl);
    beat_t b;
    b.op   = o;
    b.ch   = c;
    b.back = bk;
    b.col  = cl;
    b.aim  = 1'b0;
    return b;
  endfunction

  // steer a read into the live history and below the line length most of the
  // time, so that stored cells are actually compared
  function automatic beat_t aim_read(beat_t b);
    int span;
    int line;
    int pick;
    span = (ring_head + NLINES - ring_tail) % NLINES;
    if (span > 0 && $urandom_range(0, 9) < 8)
      b.back = tclr_pkg::BACK_W'($urandom_range(0, span - 1));
    line = (ring_head + NLINES - b.back) % NLINES;
    pick = $urandom_range(0, 7);
    if (pick < 5 && ring_len[line] > 0) begin
      b.col = tclr_pkg::COL_W'($urandom_range(0, ring_len[line] - 1));
    end else if (pick == 5 && ring_len[line] < NCOLS) begin
      b.col = tclr_pkg::COL_W'(ring_len[line]);   // first cell past the end of the line
    end
    return b;
  endfunction

  // mostly printable text with line control, some reads, rare clears and noise
  function automatic beat_t random_beat();
    beat_t b;
    int    r;
    b.op   = tclr_pkg::OP_PUT;
    b.ch   = tclr_pkg::CHAR_W'($urandom);
    b.back = tclr_pkg::BACK_W'($urandom);
    b.col  = tclr_pkg::COL_W'($urandom);
    b.aim  = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 52) begin
      b.ch = tclr_pkg::CHAR_W'($urandom_range(tclr_pkg::PRINT_LO, tclr_pkg::PRINT_HI));
    end else if (r < 60) begin
      b.ch = tclr_pkg::CH_NEWLINE;
    end else if (r < 64) begin
      b.ch = tclr_pkg::CH_BACKSPACE;
    end else if (r < 66) begin
      b.ch = tclr_pkg::CH_RETURN;
    end else if (r < 70) begin
      // codes that should be dropped
      b.ch = tclr_pkg::CHAR_W'($urandom_range(0, 1)
               ? $urandom_range(tclr_pkg::PRINT_HI + 1, 255)
               : $urandom_range(0, tclr_pkg::PRINT_LO - 1));
    end else if (r < 93) begin
      b.op  = tclr_pkg::OP_READ;
      b.aim = 1'b1;
    end else if (r < 94) begin
      b.op = tclr_pkg::OP_CLEAR;
    end else if (r < 96) begin
      b.op = OP_SPARE;
    end
    // remaining few: a put of any byte at all
    return b;
  endfunction

  // drive one beat after a drawn gap and hold it until it is taken
  task automatic send_beat(beat_t b);
    int gap;
    gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    // predictor has caught up with every earlier beat by this falling edge
    if (b.aim) b = aim_read(b);
    op         = b.op;
    char_code  = b.ch;
    lines_back = b.back;
    column     = b.col;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // stop sending and wait for every predicted result to come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // register write, only ever with the unit idle
  task automatic set_limit(int value);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = tclr_pkg::LIMIT_W'(value);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic void report(string what, cell_read_t want, cell_read_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected char %0d len %0d hist %0d, got char %0d len %0d hist %0d",
               $realtime, what, want.ch, want.len, want.hist, got.ch, got.len, got.hist);
  endfunction

  // ------------------------------------------------------------------
  // predictor update and result check, both on the rising edge
  // ------------------------------------------------------------------
  always @(posedge clk) begin : ring_check
    cell_read_t got;
    cell_read_t want;
    beat_t      b;
    if (!rst) begin
      if (cfg_we) ring_limit = int'(cfg_wdata);
      // push before pop so a same-cycle result would still line up
      if (in_valid && in_ready) begin
        b = mk_beat(op, char_code, lines_back, column);
        pending_q.push_back(predict_beat(b));
      end
      if (out_valid && out_ready) begin
        got.ch   = read_char;
        got.len  = line_length;
        got.hist = in_history;
        if (pending_q.size() == 0) begin
          report("result with no beat waiting", '0, got);
        end else begin
          want = pending_q.pop_front();
          if (got.ch !== want.ch || got.len !== want.len || got.hist !== want.hist)
            report("result mismatch", want, got);
        end
      end
    end
  end

  // receiver: a drawn stall before each result, then ready until one is taken
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = out_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // fresh ring: only the head line is in history, and it is empty
  task automatic test_reset_state();
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'hFF, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd1, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h55, 5'd31, 7'd127));
  endtask

  // printable range edges, dropped codes, backspace, return, newline,
  // spare op and clear with an empty ring behind it
  task automatic test_control_chars();
    send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::PRINT_LO, 5'd31, 7'd127));
    send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::PRINT_HI, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::PRINT_LO - 8'd1, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::PRINT_HI + 8'd1, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, 8'hFF, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, 8'h00, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd0, 7'd1));
    send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::CH_BACKSPACE, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::CH_BACKSPACE, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::CH_BACKSPACE, 5'd0, 7'd0));   // already empty
    send_beat(mk_beat(tclr_pkg::OP_PUT, "q", 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::CH_RETURN, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, "z", 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::CH_NEWLINE, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd1, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd0, 7'd0));
    send_beat(mk_beat(OP_SPARE, 8'hFF, 5'd31, 7'd127));
    send_beat(mk_beat(tclr_pkg::OP_CLEAR, 8'hFF, 5'd31, 7'd127));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd0, 7'd0));        // head meets tail
    send_beat(mk_beat(tclr_pkg::OP_PUT, "k", 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd0, 7'd0));
  endtask

  // limit zero wraps on every character; the top limit fills a whole line
  task automatic test_limit_extremes();
    set_limit(0);
    send_beat(mk_beat(tclr_pkg::OP_PUT, "a", 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, "b", 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::CH_BACKSPACE, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd1, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd2, 7'd0));
    set_limit(127);
    for (int i = 0; i < NCOLS + 2; i++)
      send_beat(mk_beat(tclr_pkg::OP_PUT,
                        tclr_pkg::PRINT_LO + tclr_pkg::CHAR_W'(i % 100), 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd1, 7'd127));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd1, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd0, 7'd1));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd0, 7'd2));
    set_limit(1);
    send_beat(mk_beat(tclr_pkg::OP_PUT, "x", 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_PUT, "y", 5'd0, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd1, 7'd1));
    set_limit(int'(tclr_pkg::LIMIT_RESET));
  endtask

  // more newlines than lines, so the tail is pushed round the ring
  task automatic test_ring_wrap();
    in_idle  = 1'b0;   // back-to-back stretch
    out_idle = 1'b0;
    send_beat(mk_beat(tclr_pkg::OP_CLEAR, 8'h00, 5'd0, 7'd0));
    for (int i = 0; i < NLINES + 2; i++) begin
      send_beat(mk_beat(tclr_pkg::OP_PUT, "A" + tclr_pkg::CHAR_W'(i % 26), 5'd0, 7'd0));
      send_beat(mk_beat(tclr_pkg::OP_PUT, tclr_pkg::CH_NEWLINE, 5'd0, 7'd0));
    end
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd30, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd31, 7'd0));
    send_beat(mk_beat(tclr_pkg::OP_READ, 8'h00, 5'd1, 7'd0));
    in_idle  = 1'b1;
    out_idle = 1'b1;
  endtask

  // random text under a sweep of limits, idling modes redrawn in stretches
  task automatic test_random();
    int limits [7];
    limits = '{50, 1, 126, 0, 127, 2, 0};
    for (int p = 0; p < 7; p++) begin
      set_limit((p == 6) ? $urandom_range(1, 126) : limits[p]);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i % 40 == 0) begin
          in_idle  = ($urandom_range(0, 3) != 0);
          out_idle = ($urandom_range(0, 3) != 0);
        end
        // hold off mid-phase until the unit has emptied
        if (i == PHASE_BEATS / 2) wait_drained();
        send_beat(random_beat());
      end
    end
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (2 * SETTLE) @(posedge clk);
    // anything still predicted here never came back
    mismatches += pending_q.size();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = tclr_pkg::LIMIT_RESET;
    in_valid   = 1'b0;
    op         = tclr_pkg::OP_PUT;
    char_code  = '0;
    lines_back = '0;
    column     = '0;
    in_idle    = 1'b1;
    out_idle   = 1'b1;
    mismatches = 0;
    ring_reset();
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_control_chars();
    test_limit_extremes();
    test_ring_wrap();
    test_random();
    finish_run();
  end

endmodule
